[sv/accel_tilt_and_temp_convert_top_macros.svh]
// ----------------------------------------------------------------------------
// accel tilt and temperature converter assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in rst
// ----------------------------------------------------------------------------
`ifndef ACCEL_TILT_AND_TEMP_CONVERT_TOP_MACROS_SVH
`define ACCEL_TILT_AND_TEMP_CONVERT_TOP_MACROS_SVH

// condition holds at every edge
`define ATC_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ATC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/atc_pkg.sv]
// ----------------------------------------------------------------------------
// atc_pkg
// shared types, constants and the arctangent table of the tilt converter
// ----------------------------------------------------------------------------
package atc_pkg;

  localparam int ROOT_W        = 32;
  localparam int CORDIC_STEPS  = 32;
  localparam int CORDIC_W      = 36;
  localparam int MAG_W         = 33;
  localparam int FRONT_STAGES  = 2;
  localparam int POST_STAGES   = 4;
  localparam int TEMP_STAGES   = 4;
  localparam int LATENCY       = FRONT_STAGES + ROOT_W + CORDIC_STEPS + POST_STAGES;

  localparam logic [63:0] PI_Q60          = 64'h3243F6A8885A308D;
  localparam logic [28:0] RAD_TO_CDEG_Q16 = 29'd375493621;

  localparam logic [19:0] RECIP_17       = 20'd986896;
  localparam int          RECIP_17_SHIFT = 24;
  localparam logic [22:0] RECIP_85       = 23'd6316129;
  localparam int          RECIP_85_SHIFT = 29;

  localparam int ANGLE_MAX = 9000;
  localparam int TC_MIN    = -20000;
  localparam int TC_MAX    = 20000;
  localparam int TF_MIN    = -32000;
  localparam int TF_MAX    = 40000;

  localparam logic signed [15:0] TEMP_OFFSET_RST = -16'sd1600;

  typedef struct packed {
    logic              vld;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
  } tilt_side_t;

  // atan(2^-idx) in q32 radians, taylor series in q62 then rounded
  function automatic logic signed [CORDIC_W-1:0] atan_q32(input int unsigned idx);
    logic [63:0] acc;
    logic [63:0] term;
    int unsigned e;
    acc = '0;
    if (idx == 0) begin
      return CORDIC_W'((PI_Q60 + (64'd1 << 29)) >> 30);
    end
    for (int unsigned k = 0; k < 32; k++) begin
      e = idx * (2 * k + 1);
      if (e <= 62) begin
        term = (64'd1 << (62 - e)) / 64'(2 * k + 1);
        if (k[0]) begin
          acc = acc - term;
        end else begin
          acc = acc + term;
        end
      end
    end
    return CORDIC_W'((acc + (64'd1 << 29)) >> 30);
  endfunction

endpackage

[sv/atc_isqrt.sv]
// ----------------------------------------------------------------------------
// atc_isqrt
// two-lane pipelined square root, one root bit per stage
// ----------------------------------------------------------------------------
module atc_isqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  atc_pkg::tilt_side_t          side_in,
  input  logic [atc_pkg::ROOT_W-1:0]   sq_in [2],
  output atc_pkg::tilt_side_t          side_out,
  output logic [atc_pkg::ROOT_W-1:0]   root_out [2]
);

  localparam int N  = atc_pkg::ROOT_W;
  localparam int RW = 2 * N + 2;

  atc_pkg::tilt_side_t side [N];
  logic [N-1:0]        rt [2][N];
  logic [RW-1:0]       rm [2][N];

  for (genvar g = 0; g < N; g++) begin : g_stage
    atc_pkg::tilt_side_t side_prev;
    if (g == 0) begin : g_first
      assign side_prev = side_in;
    end else begin : g_rest
      assign side_prev = side[g-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        side[g].vld <= 1'b0;
      end else if (en) begin
        side[g] <= side_prev;
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      localparam int K = N - 1 - g;
      logic [N-1:0]  rt_prev;
      logic [RW-1:0] rm_prev;
      logic [RW-1:0] trial;

      if (g == 0) begin : g_first
        assign rt_prev = '0;
        assign rm_prev = {2'b00, sq_in[l], {N{1'b0}}};
      end else begin : g_rest
        assign rt_prev = rt[l][g-1];
        assign rm_prev = rm[l][g-1];
      end

      assign trial = ({{(N+2){1'b0}}, rt_prev} << (K + 1)) + (RW'(1) << (2 * K));

      always_ff @(posedge clk) begin
        if (en) begin
          if (rm_prev >= trial) begin
            rm[l][g] <= rm_prev - trial;
            rt[l][g] <= rt_prev | (N'(1) << K);
          end else begin
            rm[l][g] <= rm_prev;
            rt[l][g] <= rt_prev;
          end
        end
      end
    end
  end

  assign side_out    = side[N-1];
  assign root_out[0] = rt[0][N-1];
  assign root_out[1] = rt[1][N-1];

endmodule

[sv/atc_cordic.sv]
// ----------------------------------------------------------------------------
// atc_cordic
// two-lane pipelined vectoring cordic and scaling to hundredths of a degree
// ----------------------------------------------------------------------------
module atc_cordic (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  atc_pkg::tilt_side_t         side_in,
  input  logic [atc_pkg::ROOT_W-1:0]  root_in [2],
  output logic                        vld_out,
  output logic signed [14:0]          pitch_angle,
  output logic signed [14:0]          roll_angle
);

  localparam int N  = atc_pkg::CORDIC_STEPS;
  localparam int W  = atc_pkg::CORDIC_W;
  localparam int MW = atc_pkg::MAG_W;
  localparam int S  = N + atc_pkg::POST_STAGES;

  atc_pkg::tilt_side_t side [S];
  logic signed [W-1:0] xr [2][N];
  logic signed [W-1:0] yr [2][N];
  logic signed [W-1:0] ang [2][N];
  logic signed [14:0]  res [2];

  for (genvar g = 0; g < S; g++) begin : g_side
    atc_pkg::tilt_side_t side_prev;
    if (g == 0) begin : g_first
      assign side_prev = side_in;
    end else begin : g_rest
      assign side_prev = side[g-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        side[g].vld <= 1'b0;
      end else if (en) begin
        side[g] <= side_prev;
      end
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic signed [15:0] a_in;
    logic               zero_num;
    logic               neg1, neg2, neg3;
    logic [MW-1:0]      mag;
    logic [44:0]        plo;
    logic [45:0]        phi;
    logic [63:0]        rsum;
    logic [14:0]        h;
    logic signed [15:0] hs;

    assign a_in     = (l == 0) ? side_in.ax : side_in.ay;
    assign zero_num = (l == 0) ? (side[N+2].ax == 16'sd0) : (side[N+2].ay == 16'sd0);

    for (genvar g = 0; g < N; g++) begin : g_step
      localparam logic signed [W-1:0] AT = atc_pkg::atan_q32(g);
      logic signed [W-1:0] x_prev, y_prev, a_prev, dx, dy;

      if (g == 0) begin : g_first
        assign x_prev = {{(W-atc_pkg::ROOT_W){1'b0}}, root_in[l]};
        assign y_prev = {{(W-32){a_in[15]}}, a_in, 16'b0};
        assign a_prev = '0;
      end else begin : g_rest
        assign x_prev = xr[l][g-1];
        assign y_prev = yr[l][g-1];
        assign a_prev = ang[l][g-1];
      end

      assign dx = y_prev >>> g;
      assign dy = x_prev >>> g;

      always_ff @(posedge clk) begin
        if (en) begin
          if (!y_prev[W-1]) begin
            xr[l][g]  <= x_prev + dx;
            yr[l][g]  <= y_prev - dy;
            ang[l][g] <= a_prev + AT;
          end else begin
            xr[l][g]  <= x_prev - dx;
            yr[l][g]  <= y_prev + dy;
            ang[l][g] <= a_prev - AT;
          end
        end
      end
    end

    assign rsum = {2'b00, phi, 16'b0} + {19'b0, plo} + (64'd1 << 47);
    assign hs   = neg3 ? -$signed({1'b0, h}) : $signed({1'b0, h});

    always_ff @(posedge clk) begin
      if (en) begin
        neg1 <= ang[l][N-1][W-1];
        mag  <= ang[l][N-1][W-1] ? MW'(-ang[l][N-1]) : MW'(ang[l][N-1]);
        neg2 <= neg1;
        plo  <= mag[15:0] * atc_pkg::RAD_TO_CDEG_Q16;
        phi  <= mag[MW-1:16] * atc_pkg::RAD_TO_CDEG_Q16;
        neg3 <= neg2;
        h    <= rsum[62:48];
        if (zero_num) begin
          res[l] <= '0;
        end else if (hs > 16'(atc_pkg::ANGLE_MAX)) begin
          res[l] <= 15'(atc_pkg::ANGLE_MAX);
        end else if (hs < -16'(atc_pkg::ANGLE_MAX)) begin
          res[l] <= -15'(atc_pkg::ANGLE_MAX);
        end else begin
          res[l] <= 15'(hs);
        end
      end
    end
  end

  assign vld_out     = side[S-1].vld;
  assign pitch_angle = res[0];
  assign roll_angle  = res[1];

endmodule

[sv/atc_temp.sv]
// ----------------------------------------------------------------------------
// atc_temp
// temperature scaling to celsius and fahrenheit, delayed to the angle latency
// ----------------------------------------------------------------------------
module atc_temp (
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] temp_raw,
  input  logic signed [15:0] temp_offset,
  output logic signed [15:0] temp_celsius,
  output logic signed [16:0] temp_fahrenheit
);

  localparam int DLY = atc_pkg::LATENCY - atc_pkg::TEMP_STAGES;

  logic signed [16:0] s;
  logic signed [19:0] nc;
  logic signed [23:0] nf;
  logic [19:0]        absc;
  logic [23:0]        absf;
  logic [23:0]        sumf;
  logic               negc2, negf2, negc3, negf3;
  logic [18:0]        mc;
  logic [21:0]        mf;
  logic [38:0]        prodc;
  logic [44:0]        prodf;
  logic [14:0]        qc;
  logic [15:0]        qf;
  logic signed [16:0] tcs;
  logic signed [17:0] tfs;
  logic signed [15:0] tc4;
  logic signed [16:0] tf4;
  logic signed [15:0] tc_d [DLY];
  logic signed [16:0] tf_d [DLY];

  assign s     = 17'(temp_raw) + 17'(temp_offset);
  assign absc  = nc[19] ? 20'(-nc) : 20'(nc);
  assign absf  = nf[23] ? 24'(-nf) : 24'(nf);
  assign sumf  = absf + 24'd85;
  assign prodc = mc * atc_pkg::RECIP_17;
  assign prodf = mf * atc_pkg::RECIP_85;
  assign tcs   = negc3 ? -$signed({2'b00, qc}) : $signed({2'b00, qc});
  assign tfs   = negf3 ? -$signed({2'b00, qf}) : $signed({2'b00, qf});

  always_ff @(posedge clk) begin
    if (en) begin
      nc    <= 20'(s) * 20'sd5 + 20'sd62101;
      nf    <= 24'(s) * 24'sd90 + 24'sd1661818;
      negc2 <= nc[19];
      negf2 <= nf[23];
      mc    <= 19'(absc + 20'd8);
      mf    <= sumf[22:1];
      negc3 <= negc2;
      negf3 <= negf2;
      qc    <= 15'(prodc >> atc_pkg::RECIP_17_SHIFT);
      qf    <= 16'(prodf >> atc_pkg::RECIP_85_SHIFT);
      if (tcs > 17'(atc_pkg::TC_MAX)) begin
        tc4 <= 16'(atc_pkg::TC_MAX);
      end else if (tcs < 17'(atc_pkg::TC_MIN)) begin
        tc4 <= 16'(atc_pkg::TC_MIN);
      end else begin
        tc4 <= 16'(tcs);
      end
      if (tfs > 18'(atc_pkg::TF_MAX)) begin
        tf4 <= 17'(atc_pkg::TF_MAX);
      end else if (tfs < 18'(atc_pkg::TF_MIN)) begin
        tf4 <= 17'(atc_pkg::TF_MIN);
      end else begin
        tf4 <= 17'(tfs);
      end
    end
  end

  for (genvar g = 0; g < DLY; g++) begin : g_dly
    logic signed [15:0] tc_prev;
    logic signed [16:0] tf_prev;
    if (g == 0) begin : g_first
      assign tc_prev = tc4;
      assign tf_prev = tf4;
    end else begin : g_rest
      assign tc_prev = tc_d[g-1];
      assign tf_prev = tf_d[g-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tc_d[g] <= tc_prev;
        tf_d[g] <= tf_prev;
      end
    end
  end

  assign temp_celsius    = tc_d[DLY-1];
  assign temp_fahrenheit = tf_d[DLY-1];

endmodule

[sv/accel_tilt_and_temp_convert_top.sv]
// items pass the front registers, square root, cordic and scaling stages to the output
// throughput: one item per cycle; 32 square root stages and 32 cordic stages set the depth
// a stalled output holds the whole pipeline in place, bubbles travel as invalid slots
// reset clears every valid bit and loads temp_offset with -1600
// ----------------------------------------------------------------------------
// accel_tilt_and_temp_convert_top
// pitch and roll from three acceleration axes, die temperature in c and f
// ----------------------------------------------------------------------------
`include "accel_tilt_and_temp_convert_top_macros.svh"

module accel_tilt_and_temp_convert_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  input  logic signed [15:0] temp_raw,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [14:0] pitch_angle,
  output logic signed [14:0] roll_angle,
  output logic signed [15:0] temp_celsius,
  output logic signed [16:0] temp_fahrenheit,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic signed [15:0] cfg_data
);

  logic                en;
  logic signed [15:0]  temp_offset;
  atc_pkg::tilt_side_t side1, side2, side_root;
  logic signed [31:0]  px, py, pz;
  logic [31:0]         sqx, sqy, sqz;
  logic [31:0]         sq2 [2];
  logic [31:0]         root [2];

  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_offset <= atc_pkg::TEMP_OFFSET_RST;
    end else if (cfg_valid && cfg_ready) begin
      temp_offset <= cfg_data;
    end
  end

  assign px = accel_x * accel_x;
  assign py = accel_y * accel_y;
  assign pz = accel_z * accel_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      side1.vld <= 1'b0;
      side2.vld <= 1'b0;
    end else if (en) begin
      side1.vld <= in_valid;
      side2.vld <= side1.vld;
    end
    if (en) begin
      side1.ax <= accel_x;
      side1.ay <= accel_y;
      sqx      <= $unsigned(px);
      sqy      <= $unsigned(py);
      sqz      <= $unsigned(pz);
      side2.ax <= side1.ax;
      side2.ay <= side1.ay;
      sq2[0]   <= sqy + sqz;
      sq2[1]   <= sqx + sqz;
    end
  end

  atc_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .side_in  (side2),
    .sq_in    (sq2),
    .side_out (side_root),
    .root_out (root)
  );

  atc_cordic u_cordic (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .side_in     (side_root),
    .root_in     (root),
    .vld_out     (out_valid),
    .pitch_angle (pitch_angle),
    .roll_angle  (roll_angle)
  );

  atc_temp u_temp (
    .clk             (clk),
    .en              (en),
    .temp_raw        (temp_raw),
    .temp_offset     (temp_offset),
    .temp_celsius    (temp_celsius),
    .temp_fahrenheit (temp_fahrenheit)
  );

  `ATC_ASSERT(a_pitch_range,
    !out_valid || (pitch_angle <= 15'sd9000 && pitch_angle >= -15'sd9000),
    "pitch out of range")
  `ATC_ASSERT(a_roll_range,
    !out_valid || (roll_angle <= 15'sd9000 && roll_angle >= -15'sd9000),
    "roll out of range")
  `ATC_ASSERT(a_temp_range,
    !out_valid || (temp_celsius <= 16'sd20000 && temp_celsius >= -16'sd20000 &&
    temp_fahrenheit <= 17'sd40000 && temp_fahrenheit >= -17'sd32000),
    "temperature out of range")
  `ATC_ASSERT_NEXT(a_stall_hold, out_valid && out_stall,
    out_valid && $stable(pitch_angle) && $stable(temp_celsius), "stalled result lost")

endmodule
